// File: hw/rtl/ssp_pkg.sv
// types and constants shared by the successor position search block
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

    // fixed field widths of the item channels
    localparam int OPCODE_W = 2;
    localparam int ITEM_W   = 16;
    localparam int POS_W    = 9;
    localparam int STATUS_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } ssp_opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } ssp_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } ssp_state_t;

    typedef struct packed {
        ssp_opcode_t       opcode;
        logic [ITEM_W-1:0] item_value;
    } ssp_in_t;

    typedef struct packed {
        logic [POS_W-1:0] target_position;
        logic             wrapped_to_min;
        ssp_status_t      status;
    } ssp_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/ssp_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ssp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/successor_position_search.sv
// Successor position search: ordered value list with a successor query.
// Opcode clear empties the list and gives no item; append stores the value at
// the next position and returns that position (status full, position 0, when
// the list holds LIST_DEPTH values); query returns the position of the smallest
// stored value strictly greater than the query value, earliest on ties, or the
// position of the minimum with wrapped_to_min set when none is greater, and
// status empty on an empty list. After a clear the block is ready again at
// once; an append loads the result register and then the output register. A
// query scans the stored values: the list ram has one read port, so the scan
// reads one entry per cycle into a single comparator stage. The block is not
// ready while a query scans or while a result waits for the output register.
// Positions wider than 9 bits are truncated on the result.
`timescale 1ns / 1ps
`default_nettype none

module successor_position_search #(
    parameter int LIST_DEPTH = 512,
    parameter int VALUE_BITS = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire ssp_pkg::ssp_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ssp_pkg::ssp_out_t     m_data
);

    import ssp_pkg::*;

    localparam int IW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    ssp_state_t            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         issue_reg, issue_next;
    logic                  dv_reg, dv_next;
    logic [IW-1:0]         dpos_reg, dpos_next;
    logic [VALUE_BITS-1:0] query_reg, query_next;
    logic                  found_reg, found_next;
    logic [VALUE_BITS-1:0] best_val_reg, best_val_next;
    logic [IW-1:0]         best_pos_reg, best_pos_next;
    logic [VALUE_BITS-1:0] min_val_reg, min_val_next;
    logic [IW-1:0]         min_pos_reg, min_pos_next;
    ssp_out_t              res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    ssp_out_t              m_data_reg, m_data_next;

    logic                  accept;
    logic                  ram_we;
    logic [IW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic [VALUE_BITS-1:0] in_val;
    logic                  is_full;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign in_val  = VALUE_BITS'(s_data.item_value);
    assign is_full = (count_reg == CW'(LIST_DEPTH));
    assign ram_we  = accept && (s_data.opcode == OP_APPEND) && !is_full;

    // list storage
    ssp_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(LIST_DEPTH)
    ) u_list_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(count_reg[IW-1:0]),
        .wdata(in_val),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            dv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dv_reg      <= dv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        issue_reg    <= issue_next;
        dpos_reg     <= dpos_next;
        query_reg    <= query_next;
        found_reg    <= found_next;
        best_val_reg <= best_val_next;
        best_pos_reg <= best_pos_next;
        min_val_reg  <= min_val_next;
        min_pos_reg  <= min_pos_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    // sequencer, scan compare and output register
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        dv_next       = 1'b0;
        dpos_next     = dpos_reg;
        query_next    = query_reg;
        found_next    = found_reg;
        best_val_next = best_val_reg;
        best_pos_next = best_pos_reg;
        min_val_next  = min_val_reg;
        min_pos_next  = min_pos_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        ram_raddr     = issue_reg[IW-1:0];

        // output register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_data.opcode)
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_APPEND: begin
                            res_next.wrapped_to_min = 1'b0;
                            if (is_full) begin
                                res_next.target_position = '0;
                                res_next.status          = ST_FULL;
                            end else begin
                                res_next.target_position = POS_W'(count_reg[IW-1:0]);
                                res_next.status          = ST_OK;
                                count_next               = count_reg + 1'b1;
                            end
                            state_next = S_RESULT;
                        end
                        OP_QUERY: begin
                            if (count_reg == '0) begin
                                res_next.target_position = '0;
                                res_next.wrapped_to_min  = 1'b0;
                                res_next.status          = ST_EMPTY;
                                state_next               = S_RESULT;
                            end else begin
                                query_next = in_val;
                                issue_next = '0;
                                found_next = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue one read per cycle
                if (issue_reg != count_reg) begin
                    dv_next    = 1'b1;
                    dpos_next  = issue_reg[IW-1:0];
                    issue_next = issue_reg + 1'b1;
                end
                // compare the entry read in the previous cycle
                if (dv_reg) begin
                    if ((dpos_reg == '0) || (ram_rdata < min_val_reg)) begin
                        min_val_next = ram_rdata;
                        min_pos_next = dpos_reg;
                    end
                    if ((ram_rdata > query_reg)
                            && (!found_reg || (ram_rdata < best_val_reg))) begin
                        found_next    = 1'b1;
                        best_val_next = ram_rdata;
                        best_pos_next = dpos_reg;
                    end
                end else if (issue_reg == count_reg) begin
                    res_next.status = ST_OK;
                    if (found_reg) begin
                        res_next.target_position = POS_W'(best_pos_reg);
                        res_next.wrapped_to_min  = 1'b0;
                    end else begin
                        res_next.target_position = POS_W'(min_pos_reg);
                        res_next.wrapped_to_min  = 1'b1;
                    end
                    state_next = S_RESULT;
                end
            end

            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
